// ===== rtl/core/spq_pkg.sv =====
// shared types, constants and codes for the sorted priority queue
package spq_pkg;

	localparam int DEPTH_DEF = 8;
	localparam int DATA_W    = 32;
	localparam int COUNT_W   = 4;

	// operation codes carried in func
	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_DELETE = 1'b1;

	// result status codes
	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	// operation broadcast to every cell
	typedef struct packed {
		logic                     ins;
		logic                     del;
		logic signed [DATA_W-1:0] value;
	} ctrl_t;

	// per-cell compare results
	typedef struct packed {
		logic place; // new value goes at or before this cell
		logic le;    // valid and entry <= value
		logic eq;    // valid and entry == value
	} flags_t;

endpackage

// ===== rtl/core/spq_if.sv =====
// valid/ready channel interfaces for request and response words
interface spq_req_if;
	logic                             valid;
	logic                             ready;
	logic                             func;
	logic signed [spq_pkg::DATA_W-1:0] value;

	modport source (output valid, output func, output value, input ready);
	modport sink   (input valid, input func, input value, output ready);
endinterface

interface spq_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [1:0]                        status;
	logic [spq_pkg::COUNT_W-1:0]       count;
	logic signed [spq_pkg::DATA_W-1:0] head_value;

	modport source (output valid, output status, output count, output head_value, input ready);
	modport sink   (input valid, input status, input count, input head_value, output ready);
endinterface

// ===== rtl/core/sorted_priority_queue_core.sv =====
// a result word appears in the cycle after its request word is accepted
// throughput: one request word per cycle while result words are taken; all cells compare and shift in parallel
// a new request is taken in the same cycle that the pending result is taken
// reset clears the fill count and the result valid; cell contents stay undefined
// cells at or beyond the fill count are never shown at the output
module sorted_priority_queue_core #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	spq_req_if.sink       req,
	spq_rsp_if.source     rsp
);

	localparam int CntW = $clog2(DEPTH + 1);

	logic [CntW-1:0]                   cnt_q;
	logic [CntW-1:0]                   cnt_d;
	logic                              rsp_valid_q;
	spq_pkg::status_t                  status_q;
	spq_pkg::status_t                  status_d;
	logic                              acc;
	logic                              full;
	logic                              empty;
	logic                              found;
	spq_pkg::ctrl_t                    ctrl;
	logic signed [spq_pkg::DATA_W-1:0] entry_w [DEPTH];
	spq_pkg::flags_t                   flags_w [DEPTH];
	logic [DEPTH-1:0]                  eq_vec;

	// accept when the result slot is free or being emptied
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign acc       = req.valid && req.ready;
	assign full      = (cnt_q == CntW'(DEPTH));
	assign empty     = (cnt_q == '0);
	assign found     = |eq_vec;

	// operation decode and status
	always_comb begin
		ctrl.value = req.value;
		ctrl.ins   = 1'b0;
		ctrl.del   = 1'b0;
		cnt_d      = cnt_q;
		status_d   = spq_pkg::ST_DONE;
		if (req.func == spq_pkg::FUNC_INSERT) begin
			if (full) begin
				status_d = spq_pkg::ST_OVERFLOW;
			end else begin
				ctrl.ins = acc;
				cnt_d    = cnt_q + 1'b1;
			end
		end else begin
			if (empty) begin
				status_d = spq_pkg::ST_EMPTY;
			end else if (!found) begin
				status_d = spq_pkg::ST_NOT_FOUND;
			end else begin
				ctrl.del = acc;
				cnt_d    = cnt_q - 1'b1;
			end
		end
	end

	// chain of cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                              cell_valid;
		logic signed [spq_pkg::DATA_W-1:0] left_e;
		logic                              left_p;
		logic signed [spq_pkg::DATA_W-1:0] right_e;

		assign cell_valid = (CntW'(i) < cnt_q);
		assign eq_vec[i]  = flags_w[i].eq;

		if (i == 0) begin : g_first
			assign left_e = ctrl.value;
			assign left_p = 1'b0;
		end else begin : g_mid
			assign left_e = entry_w[i-1];
			assign left_p = flags_w[i-1].place;
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_e = entry_w[i];
		end else begin : g_inner
			assign right_e = entry_w[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.valid       (cell_valid),
			.left_entry  (left_e),
			.left_place  (left_p),
			.right_entry (right_e),
			.entry       (entry_w[i]),
			.flags       (flags_w[i])
		);
	end

	// fill count and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				cnt_q       <= cnt_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// result status register
	always_ff @(posedge clk) begin
		if (acc) begin
			status_q <= status_d;
		end
	end

	// result word; cell contents hold until the word is taken
	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = status_q;
	assign rsp.count      = spq_pkg::COUNT_W'(cnt_q);
	assign rsp.head_value = empty ? '0 : entry_w[0];

	// fill count stays in range
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(DEPTH))
		else $error("fill count beyond depth");

	// a successful insert grows the count by one
	a_ins_grow: assert property (@(posedge clk) disable iff (!arst_n)
		acc && req.func == spq_pkg::FUNC_INSERT && !full |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("insert did not grow count");

	// overflow is only reported with a full store
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == spq_pkg::ST_OVERFLOW |-> full)
		else $error("overflow reported while not full");

	// not found leaves the count unchanged
	a_nf_hold: assert property (@(posedge clk) disable iff (!arst_n)
		acc && req.func == spq_pkg::FUNC_DELETE && !empty && !found |=> cnt_q == $past(cnt_q))
		else $error("miss changed count");

	// stored entries stay in descending order
	for (genvar j = 0; j < DEPTH - 1; j++) begin : g_order_chk
		a_order: assert property (@(posedge clk) disable iff (!arst_n)
			CntW'(j + 1) < cnt_q |-> entry_w[j] >= entry_w[j+1])
			else $error("store out of order");
	end

endmodule

// ===== rtl/core/spq_cell.sv =====
// one storage cell of the sorted chain: compare against the operand, shift left or right
module spq_cell (
	input  logic                             clk,
	input  spq_pkg::ctrl_t                   ctrl,
	input  logic                             valid,
	input  logic signed [spq_pkg::DATA_W-1:0] left_entry,
	input  logic                             left_place,
	input  logic signed [spq_pkg::DATA_W-1:0] right_entry,
	output logic signed [spq_pkg::DATA_W-1:0] entry,
	output spq_pkg::flags_t                  flags
);

	logic signed [spq_pkg::DATA_W-1:0] entry_q;
	logic signed [spq_pkg::DATA_W-1:0] entry_d;

	// local compares against the broadcast operand
	always_comb begin
		flags.place = !valid || (ctrl.value >= entry_q);
		flags.le    = valid && (entry_q <= ctrl.value);
		flags.eq    = valid && (entry_q == ctrl.value);
	end

	// insert takes the operand or the left neighbor, delete takes the right neighbor
	always_comb begin
		entry_d = entry_q;
		if (ctrl.ins) begin
			if (left_place) begin
				entry_d = left_entry;
			end else if (flags.place) begin
				entry_d = ctrl.value;
			end
		end else if (ctrl.del) begin
			if (flags.le) begin
				entry_d = right_entry;
			end
		end
	end

	// payload register, no reset
	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

	assign entry = entry_q;

endmodule
